// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define RSQA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define RSQA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/rsqa_pkg.sv -----
package rsqa_pkg;

    localparam int unsigned TIME_W    = 64;
    localparam int unsigned GEN_W     = 32;
    localparam int unsigned RATE_W    = 32;
    localparam int unsigned SUM_W     = 64;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned EXP_W     = 30;
    localparam int unsigned AVG_W     = 31;
    localparam int unsigned QUO_W     = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] MIN_SAMPLES_RESET = COUNT_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_RATE = 1'b0,
        CFG_MIN_SAMPLES   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        HEALTH_OK         = 2'd0,
        HEALTH_FAIL       = 2'd1,
        HEALTH_UNRELIABLE = 2'd2
    } health_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_JUDGE
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0]   rate_sum;
        logic [COUNT_W-1:0] good_count;
        logic [COUNT_W-1:0] bad_count;
    } acc_t;

endpackage

// ----- rtl/rate_sample_qualifier_average_core.sv -----
// An accepted item first updates the running state; the bit-serial average divider
// then forms the average, and the judged result is loaded into the output register once that register is free.
// A new item is taken only after the previous one is through the divider and judge.
// A new item is taken while the previous result still waits in the output register.
// Reset (aresetn low, synchronous) clears the running state, counts and handshakes
// and loads expected_rate with 0 and min_samples with 5.
`include "assert_macros.svh"

module rate_sample_qualifier_average_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wen,
    input  logic [rsqa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rsqa_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_sample_valid,
    input  logic [rsqa_pkg::TIME_W-1:0]            s_acquired_time,
    input  logic [rsqa_pkg::GEN_W-1:0]             s_sample_generation,
    input  logic signed [rsqa_pkg::RATE_W-1:0]     s_rate_value,
    input  logic                                   s_rate_not_finite,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [rsqa_pkg::AVG_W-1:0]             m_average_rate,
    output logic [1:0]                             m_health,
    output logic [rsqa_pkg::COUNT_W-1:0]           m_accepted_count,
    output logic [rsqa_pkg::COUNT_W-1:0]           m_rejected_count
);

    rsqa_pkg::state_t state_reg, state_next;

    logic [rsqa_pkg::EXP_W-1:0]   expected_rate_reg;
    logic [rsqa_pkg::COUNT_W-1:0] min_samples_reg;

    logic                         take;
    logic                         div_start;
    logic                         div_done;
    logic [rsqa_pkg::QUO_W-1:0]   quotient;
    rsqa_pkg::acc_t               acc;
    rsqa_pkg::health_t            health;
    logic                         out_free;
    logic                         out_load;

    logic                         m_valid_reg, m_valid_next;
    logic [rsqa_pkg::AVG_W-1:0]   average_reg;
    logic [1:0]                   health_reg;
    logic [rsqa_pkg::COUNT_W-1:0] accepted_reg, rejected_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_rate_reg <= '0;
            min_samples_reg   <= rsqa_pkg::MIN_SAMPLES_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                rsqa_pkg::CFG_EXPECTED_RATE: begin
                    expected_rate_reg <= cfg_wdata[rsqa_pkg::EXP_W-1:0];
                end
                rsqa_pkg::CFG_MIN_SAMPLES: begin
                    min_samples_reg <= cfg_wdata[rsqa_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign take     = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    rsqa_state u_state (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .take_i              (take),
        .sample_valid_i      (s_sample_valid),
        .acquired_time_i     (s_acquired_time),
        .sample_generation_i (s_sample_generation),
        .rate_value_i        (s_rate_value),
        .rate_not_finite_i   (s_rate_not_finite),
        .expected_rate_i     (expected_rate_reg),
        .acc_o               (acc)
    );

    rsqa_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (acc.rate_sum),
        .divisor_i  (acc.good_count),
        .done_o     (div_done),
        .quotient_o (quotient)
    );

    rsqa_judge u_judge (
        .average_i       (quotient[rsqa_pkg::AVG_W-1:0]),
        .acc_i           (acc),
        .expected_rate_i (expected_rate_reg),
        .min_samples_i   (min_samples_reg),
        .health_o        (health)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsqa_pkg::ST_IDLE: begin
                if (take) begin
                    state_next = rsqa_pkg::ST_START;
                end
            end
            rsqa_pkg::ST_START: begin
                state_next = rsqa_pkg::ST_DIVIDE;
            end
            rsqa_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = rsqa_pkg::ST_JUDGE;
                end
            end
            rsqa_pkg::ST_JUDGE: begin
                if (out_free) begin
                    state_next = rsqa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rsqa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            rsqa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            rsqa_pkg::ST_START: begin
                div_start = 1'b1;
            end
            rsqa_pkg::ST_DIVIDE: begin
            end
            rsqa_pkg::ST_JUDGE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsqa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            average_reg  <= quotient[rsqa_pkg::AVG_W-1:0];
            health_reg   <= health;
            accepted_reg <= acc.good_count;
            rejected_reg <= acc.bad_count;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_average_rate   = average_reg;
    assign m_health         = health_reg;
    assign m_accepted_count = accepted_reg;
    assign m_rejected_count = rejected_reg;

    `RSQA_ASSERT(a_one_item_at_a_time, take |=> !s_ready, "second item taken while one is at work")
    `RSQA_ASSERT_ALWAYS(a_load_only_when_free, out_load |-> (!m_valid || m_ready), "result overwritten")

endmodule

// ----- rtl/rsqa_state.sv -----
module rsqa_state (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                take_i,
    input  logic                                sample_valid_i,
    input  logic [rsqa_pkg::TIME_W-1:0]         acquired_time_i,
    input  logic [rsqa_pkg::GEN_W-1:0]          sample_generation_i,
    input  logic signed [rsqa_pkg::RATE_W-1:0]  rate_value_i,
    input  logic                                rate_not_finite_i,
    input  logic [rsqa_pkg::EXP_W-1:0]          expected_rate_i,
    output rsqa_pkg::acc_t                      acc_o
);

    logic [rsqa_pkg::GEN_W-1:0]  generation_reg, generation_next;
    logic [rsqa_pkg::TIME_W-1:0] last_time_reg, last_time_next;
    rsqa_pkg::acc_t              acc_reg, acc_next;
    logic [rsqa_pkg::RATE_W-1:0] three_exp;
    logic [rsqa_pkg::RATE_W-1:0] raw;
    logic                        reject;

    assign three_exp = {2'b00, expected_rate_i} + {1'b0, expected_rate_i, 1'b0};
    assign raw = $unsigned(rate_value_i);
    assign reject = rate_not_finite_i || raw[rsqa_pkg::RATE_W-1] || (raw > three_exp);

    always_comb begin
        logic [rsqa_pkg::TIME_W-1:0] eff_last;
        generation_next = generation_reg;
        last_time_next  = last_time_reg;
        acc_next        = acc_reg;
        eff_last        = last_time_reg;
        if (take_i && sample_valid_i && (acquired_time_i != '0)) begin
            if (sample_generation_i != generation_reg) begin
                generation_next = sample_generation_i;
                last_time_next  = '0;
                acc_next        = '0;
                eff_last        = '0;
            end
            if (acquired_time_i > eff_last) begin
                last_time_next = acquired_time_i;
                if (eff_last != '0) begin
                    if (reject) begin
                        if (acc_next.bad_count != rsqa_pkg::COUNT_MAX) begin
                            acc_next.bad_count = acc_next.bad_count + 1'b1;
                        end
                    end else if (acc_next.good_count != rsqa_pkg::COUNT_MAX) begin
                        acc_next.rate_sum   = acc_next.rate_sum +
                                              {{(rsqa_pkg::SUM_W-rsqa_pkg::RATE_W){1'b0}}, raw};
                        acc_next.good_count = acc_next.good_count + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            generation_reg <= '0;
            last_time_reg  <= '0;
            acc_reg        <= '0;
        end else begin
            generation_reg <= generation_next;
            last_time_reg  <= last_time_next;
            acc_reg        <= acc_next;
        end
    end

    assign acc_o = acc_reg;

endmodule

// ----- rtl/rsqa_div.sv -----
`include "assert_macros.svh"

module rsqa_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start_i,
    input  logic [rsqa_pkg::SUM_W-1:0]       dividend_i,
    input  logic [rsqa_pkg::COUNT_W-1:0]     divisor_i,
    output logic                             done_o,
    output logic [rsqa_pkg::QUO_W-1:0]       quotient_o
);

    localparam int unsigned STEP_W = $clog2(rsqa_pkg::QUO_W);

    logic [rsqa_pkg::COUNT_W-1:0] rem_reg, rem_next;
    logic [rsqa_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [rsqa_pkg::COUNT_W-1:0] divisor_reg, divisor_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         zero_reg, zero_next;
    logic [rsqa_pkg::COUNT_W+1:0] diff;
    logic                         borrow;

    // The quotient of a sum of 31-bit rates by their count fits in 32 bits,
    // so the upper half of the dividend is already below the divisor.
    assign diff   = {1'b0, rem_reg, quo_reg[rsqa_pkg::QUO_W-1]} - {2'b00, divisor_reg};
    assign borrow = diff[rsqa_pkg::COUNT_W+1];

    always_comb begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        zero_next    = zero_reg;
        done_next    = 1'b0;
        if (start_i) begin
            rem_next     = dividend_i[rsqa_pkg::SUM_W-1:rsqa_pkg::QUO_W];
            quo_next     = dividend_i[rsqa_pkg::QUO_W-1:0];
            divisor_next = divisor_i;
            zero_next    = (divisor_i == '0);
            step_next    = '0;
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            rem_next  = borrow ? {rem_reg[rsqa_pkg::COUNT_W-2:0], quo_reg[rsqa_pkg::QUO_W-1]}
                               : diff[rsqa_pkg::COUNT_W-1:0];
            quo_next  = {quo_reg[rsqa_pkg::QUO_W-2:0], ~borrow};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(rsqa_pkg::QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        zero_reg    <= zero_next;
    end

    assign done_o     = done_reg;
    assign quotient_o = zero_reg ? '0 : quo_reg;

    `RSQA_ASSERT(a_div_no_early_done, start_i |=> !done_o, "divider finished one cycle after start")
    `RSQA_ASSERT(a_div_done_after_busy, done_o |-> $past(busy_reg), "divider done without a run")

endmodule

// ----- rtl/rsqa_judge.sv -----
module rsqa_judge (
    input  logic [rsqa_pkg::AVG_W-1:0]   average_i,
    input  rsqa_pkg::acc_t               acc_i,
    input  logic [rsqa_pkg::EXP_W-1:0]   expected_rate_i,
    input  logic [rsqa_pkg::COUNT_W-1:0] min_samples_i,
    output rsqa_pkg::health_t            health_o
);

    localparam int unsigned BAND_W = rsqa_pkg::AVG_W + 7;
    localparam int unsigned TOT_W  = rsqa_pkg::COUNT_W + 2;

    logic [BAND_W-1:0] avg_ext, exp_ext;
    logic [BAND_W-1:0] avg_x100, exp_x67, exp_x133;
    logic [TOT_W-1:0]  total, bad_x4;
    logic              unreliable, out_of_band;

    assign avg_ext  = BAND_W'(average_i);
    assign exp_ext  = BAND_W'(expected_rate_i);
    assign avg_x100 = (avg_ext << 6) + (avg_ext << 5) + (avg_ext << 2);
    assign exp_x67  = (exp_ext << 6) + (exp_ext << 1) + exp_ext;
    assign exp_x133 = (exp_ext << 7) + (exp_ext << 2) + exp_ext;

    assign total  = TOT_W'(acc_i.good_count) + TOT_W'(acc_i.bad_count);
    assign bad_x4 = {acc_i.bad_count, 2'b00};

    assign unreliable  = (total != '0) && (bad_x4 >= total);
    assign out_of_band = (avg_x100 < exp_x67) || (avg_x100 > exp_x133);

    always_comb begin
        if (unreliable) begin
            health_o = rsqa_pkg::HEALTH_UNRELIABLE;
        end else if ((acc_i.good_count < min_samples_i) || out_of_band) begin
            health_o = rsqa_pkg::HEALTH_FAIL;
        end else begin
            health_o = rsqa_pkg::HEALTH_OK;
        end
    end

endmodule
